// ===== design/dbp_pkg.sv =====
// ----------------------------------------------------------------------------
// dbp_pkg
// Shared types, constants and tables for the Bayer dither one-bit packer.
// ----------------------------------------------------------------------------
package dbp_pkg;

    // Geometry limits
    localparam int GROUP_PIXELS     = 16;
    localparam int MAX_WIDTH_GROUPS = 64;
    localparam int MAX_ROWS         = 1024;

    // Field widths
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 8;
    localparam int LUM_W   = 8;
    localparam int PIX_W   = $clog2(GROUP_PIXELS);
    localparam int GROUP_W = 6;
    localparam int ROW_W   = 10;
    localparam int WORD_W  = 2 * GROUP_PIXELS;
    localparam int CFG_WG_W = 7;
    localparam int CFG_HR_W = 11;
    localparam int CFG_DATA_W = CFG_HR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int TABLE_DEPTH = 1 << IDX_W;

    // Register reset values
    localparam logic [CFG_WG_W-1:0] WG_RESET = CFG_WG_W'(20);
    localparam logic [CFG_HR_W-1:0] HR_RESET = CFG_HR_W'(200);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_GROUPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS  = 1'b1;

    // Item kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Luminance weights
    localparam logic [15:0] LUM_R = 16'd77;
    localparam logic [15:0] LUM_G = 16'd150;
    localparam logic [15:0] LUM_B = 16'd29;

    // Bayer 4x4 thresholds m*16+8, row-major by {row phase, column phase}
    localparam logic [LUM_W-1:0] BAYER_THRESH [16] = '{
        8'd8,   8'd136, 8'd40,  8'd168,
        8'd200, 8'd72,  8'd232, 8'd104,
        8'd56,  8'd184, 8'd24,  8'd152,
        8'd248, 8'd120, 8'd216, 8'd88
    };

    // Image geometry registers
    typedef struct packed {
        logic [CFG_WG_W-1:0] width_groups;
        logic [CFG_HR_W-1:0] height_rows;
    } t_cfg;

endpackage

// ===== design/dbp_lum_table.sv =====
// ----------------------------------------------------------------------------
// dbp_lum_table
// Palette luminance memory: computes and stores luminance on a load, reads
// it back with a registered read for a pixel. Valid bits give zero for
// entries not loaded since reset.
// ----------------------------------------------------------------------------
module dbp_lum_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic                       i_rd_en,
    input  logic [dbp_pkg::IDX_W-1:0]  i_idx,
    input  logic [dbp_pkg::COLOR_W-1:0] i_red,
    input  logic [dbp_pkg::COLOR_W-1:0] i_green,
    input  logic [dbp_pkg::COLOR_W-1:0] i_blue,
    output logic [dbp_pkg::LUM_W-1:0]  o_lum
);

    logic [dbp_pkg::LUM_W-1:0]       mem [dbp_pkg::TABLE_DEPTH];
    logic [dbp_pkg::TABLE_DEPTH-1:0] r_valid;
    logic [dbp_pkg::LUM_W-1:0]       r_rd_data;
    logic                            r_rd_ok;
    logic [15:0]                     w_sum;

    // Weighted sum, top byte is the luminance
    assign w_sum = dbp_pkg::LUM_R * 16'(i_red)
                 + dbp_pkg::LUM_G * 16'(i_green)
                 + dbp_pkg::LUM_B * 16'(i_blue);

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_idx] <= w_sum[15:8];
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_idx];
        end
    end

    // Entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_idx];
            end
        end
    end

    // Unloaded entries read as zero
    assign o_lum = r_rd_ok ? r_rd_data : '0;

endmodule

// ===== design/dbp_packer.sv =====
// ----------------------------------------------------------------------------
// dbp_packer
// Threshold compare against the Bayer matrix, bit gathering, pixel/group/row
// counters and the output word register.
// ----------------------------------------------------------------------------
module dbp_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dbp_pkg::t_cfg                 i_cfg,
    input  logic                          i_pix_vld,
    input  logic [dbp_pkg::LUM_W-1:0]     i_lum,
    output logic                          o_pix_ready,
    output logic                          o_out_vld,
    input  logic                          i_out_ready,
    output logic [dbp_pkg::WORD_W-1:0]    o_word,
    output logic [dbp_pkg::GROUP_W-1:0]   o_group,
    output logic [dbp_pkg::ROW_W-1:0]     o_row,
    output logic                          o_last
);

    localparam logic [dbp_pkg::PIX_W-1:0] PIX_LAST = dbp_pkg::PIX_W'(dbp_pkg::GROUP_PIXELS - 1);

    logic [dbp_pkg::PIX_W-1:0]        r_pix, n_pix;
    logic [dbp_pkg::GROUP_PIXELS-1:0] r_bits, n_bits;
    logic [dbp_pkg::GROUP_W-1:0]      r_group, n_group;
    logic [dbp_pkg::ROW_W-1:0]        r_row, n_row;
    logic                             r_o_vld;
    logic [dbp_pkg::WORD_W-1:0]       r_word;
    logic [dbp_pkg::GROUP_W-1:0]      r_o_group;
    logic [dbp_pkg::ROW_W-1:0]        r_o_row;
    logic                             r_o_last;

    logic                             w_emit, w_out_free, w_fire;
    logic [dbp_pkg::LUM_W-1:0]        w_thr;
    logic                             w_hit;
    logic [dbp_pkg::GROUP_PIXELS-1:0] w_bits;
    logic [dbp_pkg::CFG_WG_W-1:0]     w_wg, w_group_inc;
    logic [dbp_pkg::CFG_HR_W-1:0]     w_hr, w_row_inc;
    logic                             w_group_end, w_row_end;

    // Duplicate each source bit into two neighboring output pixels
    function automatic logic [dbp_pkg::WORD_W-1:0] double_bits(
        input logic [dbp_pkg::GROUP_PIXELS-1:0] bits
    );
        logic [dbp_pkg::WORD_W-1:0] w;
        w = '0;
        for (int k = 0; k < dbp_pkg::GROUP_PIXELS; k++) begin
            w[2*k +: 2] = {2{bits[k]}};
        end
        return w;
    endfunction

    // Handshake toward the table stage and the output register
    assign w_emit      = (r_pix == PIX_LAST);
    assign w_out_free  = !r_o_vld || i_out_ready;
    assign o_pix_ready = !w_emit || w_out_free;
    assign w_fire      = i_pix_vld && o_pix_ready;

    // Threshold compare
    assign w_thr  = dbp_pkg::BAYER_THRESH[{r_row[1:0], r_pix[1:0]}];
    assign w_hit  = (i_lum > w_thr);
    assign w_bits = r_bits | (dbp_pkg::GROUP_PIXELS'(w_hit) << r_pix);

    // Clamp geometry to its legal range
    always_comb begin
        if (i_cfg.width_groups == '0) begin
            w_wg = dbp_pkg::CFG_WG_W'(1);
        end else if (i_cfg.width_groups > dbp_pkg::CFG_WG_W'(dbp_pkg::MAX_WIDTH_GROUPS)) begin
            w_wg = dbp_pkg::CFG_WG_W'(dbp_pkg::MAX_WIDTH_GROUPS);
        end else begin
            w_wg = i_cfg.width_groups;
        end
        if (i_cfg.height_rows == '0) begin
            w_hr = dbp_pkg::CFG_HR_W'(1);
        end else if (i_cfg.height_rows > dbp_pkg::CFG_HR_W'(dbp_pkg::MAX_ROWS)) begin
            w_hr = dbp_pkg::CFG_HR_W'(dbp_pkg::MAX_ROWS);
        end else begin
            w_hr = i_cfg.height_rows;
        end
    end

    assign w_group_inc = dbp_pkg::CFG_WG_W'(r_group) + dbp_pkg::CFG_WG_W'(1);
    assign w_row_inc   = dbp_pkg::CFG_HR_W'(r_row) + dbp_pkg::CFG_HR_W'(1);
    assign w_group_end = (w_group_inc >= w_wg);
    assign w_row_end   = (w_row_inc >= w_hr);

    // Next counter values
    always_comb begin
        n_pix   = r_pix;
        n_bits  = r_bits;
        n_group = r_group;
        n_row   = r_row;
        if (w_fire) begin
            if (w_emit) begin
                n_pix  = '0;
                n_bits = '0;
                if (w_group_end) begin
                    n_group = '0;
                    n_row   = w_row_end ? '0 : w_row_inc[dbp_pkg::ROW_W-1:0];
                end else begin
                    n_group = w_group_inc[dbp_pkg::GROUP_W-1:0];
                end
            end else begin
                n_pix  = r_pix + dbp_pkg::PIX_W'(1);
                n_bits = w_bits;
            end
        end
    end

    // Hold counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix   <= '0;
            r_bits  <= '0;
            r_group <= '0;
            r_row   <= '0;
        end else begin
            r_pix   <= n_pix;
            r_bits  <= n_bits;
            r_group <= n_group;
            r_row   <= n_row;
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_word    <= double_bits(w_bits);
            r_o_group <= r_group;
            r_o_row   <= r_row;
            r_o_last  <= w_group_end && w_row_end;
        end
    end

    assign o_out_vld = r_o_vld;
    assign o_word    = r_word;
    assign o_group   = r_o_group;
    assign o_row     = r_o_row;
    assign o_last    = r_o_last;

`ifndef NO_ASSERTIONS
    // A finished group restarts with an empty bit set
    a_group_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_emit) |=> (r_pix == '0 && r_bits == '0))
        else $error("group state not cleared after word");

    // Every output pixel pair carries the same source bit
    a_pairs_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (((r_word & 32'h5555_5555) << 1) == (r_word & 32'hAAAA_AAAA)))
        else $error("output pixel pair mismatch");
`endif

endmodule

// ===== design/bayer_dither_one_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// bayer_dither_one_bit_packer_core
// Palette-indexed pixels in, 4x4 ordered-dither 1-bit words out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per item. tuser selects the kind: 0 loads palette
//   entry tdata[7:0] with color red/green/blue, 1 delivers one pixel whose
//   palette index is tdata[7:0]. Pixels arrive row-major.
//   m_axis carries one word per sixteen pixels: the doubled 32-pixel line
//   segment, its column group and source row; tlast marks the frame's last
//   word. Geometry comes from the write port (index 0 width in groups,
//   index 1 height in rows).
//   A sixteenth pixel's word reaches m_axis via the input, table read and
//   output registers. Throughput: one item per cycle unless m_axis stalls
//   the input; the memory read and the compare sit in separate register
//   stages, so a load is visible to the very next pixel.
//   Reset clears the luminance table (via valid bits), the counters and the
//   output register; geometry returns to 20 groups by 200 rows.
//   When m_axis stalls, the finished word holds in the output register and
//   up to fifteen further pixels plus two in flight are still taken; the
//   input stalls only when another word would need the occupied register.
// ----------------------------------------------------------------------------
module bayer_dither_one_bit_packer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [dbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dbp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: entry_or_pixel[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [31:0]                       s_axis_tdata,
    // tuser: opcode[0]
    input  logic                              s_axis_tuser,
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: packed_word[31:0], group_column[37:32], source_row[47:38]
    output logic [47:0]                       m_axis_tdata,
    output logic                              m_axis_tlast
);

    dbp_pkg::t_cfg                  r_cfg;
    logic                           r_s1_vld;
    logic                           r_s1_op;
    logic [dbp_pkg::IDX_W-1:0]      r_s1_idx;
    logic [dbp_pkg::COLOR_W-1:0]    r_s1_red, r_s1_green, r_s1_blue;
    logic                           r_s2_vld;

    logic                           w_s1_pix, w_s1_load, w_s1_free;
    logic                           w_s2_ready, w_rd_en;
    logic                           w_pix_ready;
    logic [dbp_pkg::LUM_W-1:0]      w_lum;
    logic [dbp_pkg::WORD_W-1:0]     w_word;
    logic [dbp_pkg::GROUP_W-1:0]    w_group;
    logic [dbp_pkg::ROW_W-1:0]      w_row;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_groups <= dbp_pkg::WG_RESET;
            r_cfg.height_rows  <= dbp_pkg::HR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                dbp_pkg::CFG_WIDTH_GROUPS: r_cfg.width_groups <= i_cfg_wdata[dbp_pkg::CFG_WG_W-1:0];
                dbp_pkg::CFG_HEIGHT_ROWS:  r_cfg.height_rows  <= i_cfg_wdata[dbp_pkg::CFG_HR_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage flow: loads retire in stage 1, pixels move on to stage 2
    assign w_s1_pix   = r_s1_vld && (r_s1_op == dbp_pkg::OP_PIXEL);
    assign w_s1_load  = r_s1_vld && (r_s1_op == dbp_pkg::OP_LOAD);
    assign w_s2_ready = !r_s2_vld || w_pix_ready;
    assign w_rd_en    = w_s1_pix && w_s2_ready;
    assign w_s1_free  = !r_s1_vld || w_s1_load || w_s2_ready;
    assign s_axis_tready = w_s1_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && s_axis_tvalid) begin
            r_s1_op    <= s_axis_tuser;
            r_s1_idx   <= s_axis_tdata[7:0];
            r_s1_red   <= s_axis_tdata[15:8];
            r_s1_green <= s_axis_tdata[23:16];
            r_s1_blue  <= s_axis_tdata[31:24];
        end
    end

    // Lookup stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_vld <= w_s1_pix;
        end
    end

    dbp_lum_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_s1_load),
        .i_rd_en (w_rd_en),
        .i_idx   (r_s1_idx),
        .i_red   (r_s1_red),
        .i_green (r_s1_green),
        .i_blue  (r_s1_blue),
        .o_lum   (w_lum)
    );

    dbp_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_vld   (r_s2_vld),
        .i_lum       (w_lum),
        .o_pix_ready (w_pix_ready),
        .o_out_vld   (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_word      (w_word),
        .o_group     (w_group),
        .o_row       (w_row),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {w_row, w_group, w_word};

`ifndef NO_ASSERTIONS
    // Input stalls only behind a pixel waiting on the lookup stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_vld && r_s1_op == dbp_pkg::OP_PIXEL && r_s2_vld))
        else $error("input stalled without a blocked pixel");

    // The table never sees a write and a read in the same cycle
    a_table_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_s1_load && w_rd_en))
        else $error("table write and read collide");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives palette loads and pixel streams into the Bayer dither packer under
// random source gaps and sink stalls, predicts every packed output word in
// the bench, and compares each word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF    = 6;
    localparam int RESET_TICKS = 8;
    localparam int DRAIN_TICKS = 10;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_TICKS  = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [dbp_pkg::WORD_W-1:0]  bits2x;
        logic [dbp_pkg::GROUP_W-1:0] grp;
        logic [dbp_pkg::ROW_W-1:0]   row;
        logic                        last;
    } t_dither_word;

    // DUT signals; the bench-driven ones are known from time zero
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_wr_en   = 1'b0;
    logic [dbp_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [dbp_pkg::CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata  = '0;
    logic                           s_axis_tuser  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [47:0]                    m_axis_tdata;
    logic                           m_axis_tlast;

    // Bench-side copy of the block state
    logic [7:0]     pal_luma [dbp_pkg::TABLE_DEPTH];
    logic [15:0]    pend_bits;
    int             pix_pos;
    int             grp_cnt;
    int             row_cnt;
    int             cfg_width;
    int             cfg_height;
    logic [7:0]     loaded_entries [$];
    t_dither_word   pending_words [$];

    // Bayer matrix levels, row-major by {row phase, column phase}
    int bayer_level [16] = '{0, 8, 2, 10, 12, 4, 14, 6, 3, 11, 1, 9, 15, 7, 13, 5};

    int   fail_count = 0;
    int   cycle_cnt  = 0;
    int   stall_left = 0;
    logic idle_en    = 1'b0;
    logic hold_on    = 1'b0;
    event hold_start;

    bayer_dither_one_bit_packer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_geom(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the predicted state by one accepted item
    function automatic void predict_item(logic op, logic [7:0] idx,
                                         logic [7:0] red, logic [7:0] green,
                                         logic [7:0] blue);
        int           luma;
        int           thr;
        int           wg;
        int           hr;
        t_dither_word w;
        if (op == dbp_pkg::OP_LOAD) begin
            luma = (77 * int'(red) + 150 * int'(green) + 29 * int'(blue)) >> 8;
            pal_luma[idx] = luma[7:0];
            loaded_entries.push_back(idx);
            return;
        end
        thr = bayer_level[(row_cnt % 4) * 4 + (pix_pos % 4)] * 16 + 8;
        if (int'(pal_luma[idx]) > thr) pend_bits[pix_pos] = 1'b1;
        if (pix_pos + 1 < dbp_pkg::GROUP_PIXELS) begin
            pix_pos++;
            return;
        end
        wg = clamp_geom(cfg_width, dbp_pkg::MAX_WIDTH_GROUPS);
        hr = clamp_geom(cfg_height, dbp_pkg::MAX_ROWS);
        for (int k = 0; k < dbp_pkg::GROUP_PIXELS; k++) begin
            w.bits2x[2*k]   = pend_bits[k];
            w.bits2x[2*k+1] = pend_bits[k];
        end
        w.grp  = grp_cnt[dbp_pkg::GROUP_W-1:0];
        w.row  = row_cnt[dbp_pkg::ROW_W-1:0];
        w.last = (grp_cnt + 1 >= wg) && (row_cnt + 1 >= hr);
        pending_words.push_back(w);
        pend_bits = '0;
        pix_pos   = 0;
        if (grp_cnt + 1 >= wg) begin
            grp_cnt = 0;
            row_cnt = (row_cnt + 1 >= hr) ? 0 : row_cnt + 1;
        end else begin
            grp_cnt++;
        end
    endfunction

    // Compare one accepted output word with the oldest prediction
    function automatic void check_word();
        t_dither_word w;
        if (pending_words.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected word: data %h last %b", m_axis_tdata, m_axis_tlast);
            return;
        end
        w = pending_words.pop_front();
        if (m_axis_tdata[31:0] !== w.bits2x || m_axis_tdata[37:32] !== w.grp ||
            m_axis_tdata[47:38] !== w.row || m_axis_tlast !== w.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display({"word mismatch: expected bits %h grp %0d row %0d last %b, ",
                          "got bits %h grp %0d row %0d last %b"},
                         w.bits2x, w.grp, w.row, w.last, m_axis_tdata[31:0],
                         m_axis_tdata[37:32], m_axis_tdata[47:38], m_axis_tlast);
        end
    endfunction

    // Sink: check each word, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_word();
        if (!i_rst_n || hold_on) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 99) < 20) begin
            stall_left = gap_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Long sink hold-off, counted here so the source keeps pushing
    initial begin
        forever begin
            @(hold_start);
            hold_on <= 1'b1;
            repeat (HOLD_TICKS) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    // Offer one item and wait until it is taken
    task automatic send_item(logic op, logic [7:0] idx, logic [7:0] red,
                             logic [7:0] green, logic [7:0] blue);
        int gap;
        if (idle_en && $urandom_range(0, 99) < 25) begin
            gap = gap_len();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {blue, green, red, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(op, idx, red, green, blue);
    endtask

    function automatic logic [7:0] pick_index();
        if (loaded_entries.size() != 0 && $urandom_range(0, 99) < 60)
            return loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(logic [7:0] idx);
        send_item(dbp_pkg::OP_PIXEL, idx, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_load();
        send_item(dbp_pkg::OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // Drop the source, drain all predicted words, let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);
    endtask

    // Write both geometry registers on consecutive edges
    task automatic set_geometry(logic [dbp_pkg::CFG_DATA_W-1:0] width_val,
                                logic [dbp_pkg::CFG_DATA_W-1:0] height_val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= dbp_pkg::CFG_WIDTH_GROUPS;
        i_cfg_wdata <= width_val;
        @(posedge i_clk);
        cfg_width = int'(width_val[dbp_pkg::CFG_WG_W-1:0]);
        i_cfg_index <= dbp_pkg::CFG_HEIGHT_ROWS;
        i_cfg_wdata <= height_val;
        @(posedge i_clk);
        cfg_height = int'(height_val[dbp_pkg::CFG_HR_W-1:0]);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Color extremes, unloaded entry, reload, one full group at reset geometry
    task automatic test_directed();
        logic [7:0] idx_set [7] = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33};
        send_pixel(8'h33);
        send_item(dbp_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(dbp_pkg::OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(dbp_pkg::OP_LOAD, 8'h55, 8'hFF, 8'h00, 8'h00);
        send_item(dbp_pkg::OP_LOAD, 8'hAA, 8'h00, 8'hFF, 8'h00);
        send_item(dbp_pkg::OP_LOAD, 8'h0F, 8'h00, 8'h00, 8'hFF);
        send_item(dbp_pkg::OP_LOAD, 8'hF0, 8'hAA, 8'h55, 8'hAA);
        for (int i = 0; i < 14; i++) send_pixel(idx_set[i % 7]);
        // overwrite a white entry with black between pixels of the group
        send_item(dbp_pkg::OP_LOAD, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF);
    endtask

    // Clamped geometry and changes that leave counters past their limits
    task automatic test_geometry_limits();
        wait_idle();
        set_geometry(11'h780, 11'h000);
        repeat (32) send_pixel(pick_index());
        wait_idle();
        set_geometry(11'h7FF, 11'h7FF);
        repeat (48) send_pixel(pick_index());
        wait_idle();
        set_geometry(11'd1, 11'd1);
        repeat (24) send_pixel(pick_index());
        wait_idle();
        set_geometry(11'd2, 11'd3);
        repeat (8 + 16 * 7) send_pixel(pick_index());
    endtask

    // Sink holds off while the source keeps offering pixels
    task automatic test_backpressure();
        wait_idle();
        set_geometry(11'd3, 11'd2);
        idle_en <= 1'b0;
        -> hold_start;
        repeat (80) send_pixel(pick_index());
    endtask

    // Random geometry per phase, random loads and pixels, random idling
    task automatic test_random_frames();
        int pick;
        logic [dbp_pkg::CFG_DATA_W-1:0] w_val;
        logic [dbp_pkg::CFG_DATA_W-1:0] h_val;
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                w_val = 11'($urandom_range(1, 3));
                h_val = 11'($urandom_range(1, 3));
            end else if (pick < 75) begin
                w_val = 11'($urandom_range(0, 1));
                h_val = 11'($urandom_range(0, 2));
            end else if (pick < 90) begin
                w_val = 11'($urandom_range(0, 2047));
                h_val = 11'($urandom_range(0, 2047));
            end else begin
                w_val = 11'(dbp_pkg::MAX_WIDTH_GROUPS);
                h_val = 11'd1;
            end
            set_geometry(w_val, h_val);
            idle_en <= (phase != 2);
            if (phase == 0) repeat (30) send_load();
            repeat (87) begin
                if ($urandom_range(0, 99) < 15) send_load();
                else send_pixel(pick_index());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < dbp_pkg::TABLE_DEPTH; i++) pal_luma[i] = '0;
        pend_bits  = '0;
        pix_pos    = 0;
        grp_cnt    = 0;
        row_cnt    = 0;
        cfg_width  = int'(dbp_pkg::WG_RESET);
        cfg_height = int'(dbp_pkg::HR_RESET);
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        idle_en <= 1'b1;
        test_geometry_limits();
        test_backpressure();
        idle_en <= 1'b1;
        test_random_frames();

        wait_idle();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== bayer_dither_one_bit_packer_core.f =====
design/dbp_pkg.sv
design/dbp_lum_table.sv
design/dbp_packer.sv
design/bayer_dither_one_bit_packer_core.sv
sim/tb_top.sv
